### sv/bb_pkg.sv
package bb_pkg;

	localparam int MAX_LINE = 2048;
	localparam int MAX_ROWS = 4096;

	localparam int PIX_W    = 16;
	localparam int COL_W    = $clog2(MAX_LINE);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int LEN_W    = 12;
	localparam int ROWS_W   = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 1'd1;

	localparam logic [LEN_W-1:0]  LINE_LENGTH_RST = 12'd642;
	localparam logic [ROWS_W-1:0] FRAME_ROWS_RST  = 13'd482;

	localparam logic signed [PIX_W-1:0] THIRD_GAIN = 16'sd21846;

	typedef logic signed [PIX_W-1:0] pix_t;

	// signed 16-bit add, clamped to the 16-bit range
	function automatic pix_t sat_add(input pix_t a, input pix_t b);
		logic signed [PIX_W:0] s;
		s = {a[PIX_W-1], a} + {b[PIX_W-1], b};
		if (s[PIX_W] != s[PIX_W-1])
			sat_add = s[PIX_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
		else
			sat_add = s[PIX_W-1:0];
	endfunction

	// x * 21846 / 65536, floor: high half of the 32-bit product
	function automatic pix_t mul_third(input pix_t a);
		logic signed [2*PIX_W-1:0] p;
		p = a * THIRD_GAIN;
		mul_third = p[2*PIX_W-1:PIX_W];
	endfunction

endpackage

### sv/bb_pix_if.sv
interface bb_pix_if import bb_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel;
	logic frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

### sv/bb_blur_if.sv
interface bb_blur_if import bb_pkg::*; ();
	logic valid;
	logic ready;
	pix_t blurred;
	logic row_end;
	logic frame_end;

	modport source (output valid, output blurred, output row_end, output frame_end, input ready);
	modport sink (input valid, input blurred, input row_end, input frame_end, output ready);
endinterface

### sv/box_blur_3x3_satmul.sv
// A request whose window completes moves through the s1, s2 and s3 registers into
// the output register, which OUT loads once the previous result has been taken.
// The first two pixels of a row only fill the window; other pixels of the first two rows
// pass MUL and VSUM (line read, scale, write back) before the next is taken; pixels that
// emit also pass OUT, and stay there while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous): counters, window and control clear, registers
// return to 642 / 482; the line memory is not cleared and needs no clearing pass.
module box_blur_3x3_satmul import bb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bb_pix_if.sink                pix,
	bb_blur_if.source             blur
);

	// Sequencer: IDLE takes requests; MUL reads the memory word and scales the
	// horizontal sum; VSUM writes the word back and forms the vertical sum;
	// OUT scales it into the output register.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_VSUM = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [LEN_W-1:0]  line_length_q;
	logic [ROWS_W-1:0] frame_rows_q;

	// position and the two previous pixels of the row
	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	pix_t             win0_q;
	pix_t             win1_q;

	// Line memory: one word per column, holding the row results of the two
	// last lines. Bits [15:0] are bank 0, [31:16] bank 1; the bank picked
	// by the row parity holds the older line and is overwritten.
	logic [2*PIX_W-1:0] line_mem [MAX_LINE];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] wr_data;
	logic               mem_we;

	// per-request pipeline registers
	pix_t             hsum_s1;
	logic [COL_W-1:0] col_s1;
	logic             bank_s1;
	logic             emit_s1;
	logic             row_end_s1;
	logic             frame_end_s1;
	pix_t             h_s2;
	pix_t             above_s2;
	pix_t             center_s2;
	pix_t             vsum_s3;

	// output register
	logic out_valid_q;
	pix_t blurred_q;
	logic row_end_q;
	logic frame_end_q;

	// clamped geometry
	logic [LEN_W-1:0]  len_c;
	logic [ROWS_W-1:0] rows_c;
	logic [COL_W-1:0]  last_col;
	logic [ROW_W-1:0]  last_row;
	logic [COL_W-1:0]  col_raw;
	logic [ROW_W-1:0]  row_raw;
	logic [COL_W-1:0]  col_c;
	logic [ROW_W-1:0]  row_c;
	logic [COL_W-1:0]  rd_addr;
	pix_t              hsum;
	pix_t              vsum;
	logic              accept;
	logic              out_load;

	always_comb begin
		if (line_length_q < LEN_W'(3))
			len_c = LEN_W'(3);
		else if (line_length_q > LEN_W'(MAX_LINE))
			len_c = LEN_W'(MAX_LINE);
		else
			len_c = line_length_q;
		if (frame_rows_q < ROWS_W'(3))
			rows_c = ROWS_W'(3);
		else if (frame_rows_q > ROWS_W'(MAX_ROWS))
			rows_c = ROWS_W'(MAX_ROWS);
		else
			rows_c = frame_rows_q;
	end

	assign last_col = COL_W'(len_c - LEN_W'(1));
	assign last_row = ROW_W'(rows_c - ROWS_W'(1));

	// frame_start restarts the counts; a count left past a shrunken
	// register is pinned to the last column / row
	assign col_raw = pix.frame_start ? '0 : column_count_q;
	assign row_raw = pix.frame_start ? '0 : row_count_q;
	assign col_c   = (col_raw > last_col) ? last_col : col_raw;
	assign row_c   = (row_raw > last_row) ? last_row : row_raw;
	assign rd_addr = col_c - COL_W'(1);

	// left = older pixel, right = incoming, center = previous
	assign hsum = sat_add(sat_add(win1_q, pix.pixel), win0_q);

	// even output rows: (above + center) + below; odd: (below + above) + center
	assign vsum = bank_s1 ? sat_add(sat_add(h_s2, above_s2), center_s2)
	                      : sat_add(sat_add(above_s2, center_s2), h_s2);

	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || blur.ready);
	assign mem_we    = (state_q == ST_VSUM);
	assign wr_data   = bank_s1 ? {h_s2, center_s2} : {center_s2, h_s2};

	assign blur.valid     = out_valid_q;
	assign blur.blurred   = blurred_q;
	assign blur.row_end   = row_end_q;
	assign blur.frame_end = frame_end_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			frame_rows_q  <= FRAME_ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data[LEN_W-1:0];
				REG_FRAME_ROWS:  frame_rows_q  <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// counters, window, sequencer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			column_count_q <= '0;
			row_count_q    <= '0;
			win0_q         <= '0;
			win1_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (out_load)
				out_valid_q <= 1'b1;
			else if (blur.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						win1_q <= win0_q;
						win0_q <= pix.pixel;
						if (col_c >= last_col) begin
							column_count_q <= '0;
							row_count_q    <= (row_c >= last_row) ? '0 : row_c + ROW_W'(1);
						end else begin
							column_count_q <= col_c + COL_W'(1);
							row_count_q    <= row_c;
						end
						// the first two pixels of a row only fill the window
						if (col_c >= COL_W'(2))
							state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_VSUM;
				ST_VSUM: state_q <= emit_s1 ? ST_OUT : ST_IDLE;
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hsum_s1      <= hsum;
			col_s1       <= rd_addr;
			bank_s1      <= row_c[0];
			emit_s1      <= (row_c >= ROW_W'(2));
			row_end_s1   <= (col_c == last_col);
			frame_end_s1 <= (col_c == last_col) && (row_c == last_row);
		end
		if (state_q == ST_MUL) begin
			h_s2      <= mul_third(hsum_s1);
			above_s2  <= bank_s1 ? rd_q[2*PIX_W-1:PIX_W] : rd_q[PIX_W-1:0];
			center_s2 <= bank_s1 ? rd_q[PIX_W-1:0] : rd_q[2*PIX_W-1:PIX_W];
		end
		if (state_q == ST_VSUM)
			vsum_s3 <= vsum;
		if (out_load) begin
			blurred_q   <= mul_third(vsum_s3);
			row_end_q   <= row_end_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	// line memory: one write port, one registered read port; the write of a
	// request lands before the next request's read is issued
	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[col_s1] <= wr_data;
		if (accept)
			rd_q <= line_mem[rd_addr];
	end

endmodule

### sv/bb_check.sv
module bb_check import bb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pix_t blurred,
	input logic row_end,
	input logic frame_end
);

	// a pending result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(blurred) && $stable(row_end) && $stable(frame_end))
		else $error("stalled result changed");

	// the last result of a frame also closes its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// nothing is offered right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered out of reset");

	// no request is taken while the one before it passes MUL, VSUM and OUT on its way out
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2)
			&& !$past(in_valid && in_ready, 3))
		else $error("result too soon after request");

endmodule

bind box_blur_3x3_satmul bb_check u_bb_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix.valid),
	.in_ready  (pix.ready),
	.out_valid (blur.valid),
	.out_ready (blur.ready),
	.blurred   (blur.blurred),
	.row_end   (blur.row_end),
	.frame_end (blur.frame_end)
);

### bench/tb_top.sv
module tb_top;
	import bb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int NUM_PHASES    = 14;
	localparam int PHASE_PIXELS  = 105;   // pixel requests per phase
	localparam int SETTLE_CYCLES = 12;    // line read-modify-write pass, padded
	localparam int HOLD_CYCLES   = 400;   // long output back-pressure stretch

	// one blurred result as it leaves the block
	typedef struct packed {
		pix_t blurred;
		logic row_end;
		logic frame_end;
	} blur_rec_t;

	// directed step: either a register write or a pixel request
	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic       flag;     // frame_start for a pixel, register index for a write
		logic [15:0] data;    // pixel bits, or register data in [12:0]
		logic       checked;  // result typed in below instead of predicted
		blur_rec_t  result;
	} dir_step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bb_pix_if  pix_ch ();
	bb_blur_if blur_ch ();

	box_blur_3x3_satmul i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.blur      (blur_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Blur predictor: own copy of the line sums, window and counters
	// ------------------------------------------------------------------
	pix_t        line_sums [2][MAX_LINE];   // horizontal thirds of the two previous rows
	pix_t        recent_px [2];             // [0] last pixel, [1] the one before
	int          next_col;
	int          next_row;
	logic [11:0] len_reg;
	logic [12:0] rows_reg;

	blur_rec_t blur_expect [$];   // predicted results, oldest first

	int  fail_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  restart_frame;   // force frame_start on the next request (line grew)
	bit  hold_request;
	int  hold_left;

	function automatic int limit(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int line_len();
		return limit(int'(len_reg), 3, MAX_LINE);
	endfunction

	function automatic pix_t clamped_add(input pix_t a, input pix_t b);
		int s;
		s = int'(a) + int'(b);
		return pix_t'(limit(s, -32768, 32767));
	endfunction

	// (a + b) + c with clamping, then x * 21846 >> 16 (floor)
	function automatic pix_t third_of(input pix_t a, input pix_t b, input pix_t c);
		int p;
		p = int'(clamped_add(clamped_add(a, b), c)) * int'(THIRD_GAIN);
		return pix_t'(p >>> 16);
	endfunction

	function automatic void blur_predict(input pix_t px, input logic fs,
			output logic produced, output blur_rec_t rec);
		int   len;
		int   rows;
		int   c;
		int   r;
		int   col;
		pix_t h;
		pix_t above;
		pix_t center;
		produced = 1'b0;
		rec      = '0;
		len      = line_len();
		rows     = limit(int'(rows_reg), 3, MAX_ROWS);
		if (fs) begin
			next_col = 0;
			next_row = 0;
		end
		// counts past a shrunken register pin to the last column / row
		c = limit(next_col, 0, len - 1);
		r = limit(next_row, 0, rows - 1);
		if (c >= 2) begin
			col    = c - 1;
			h      = third_of(recent_px[1], px, recent_px[0]);
			above  = line_sums[r % 2][col];
			center = line_sums[1 - r % 2][col];
			line_sums[r % 2][col] = h;
			if (r >= 2) begin
				// vertical order alternates with output row parity
				rec.blurred   = (r % 2 == 0) ? third_of(above, center, h)
				                             : third_of(h, above, center);
				rec.row_end   = (c == len - 1);
				rec.frame_end = (c == len - 1) && (r == rows - 1);
				produced      = 1'b1;
			end
		end
		recent_px[1] = recent_px[0];
		recent_px[0] = px;
		if (c >= len - 1) begin
			next_col = 0;
			next_row = (r >= rows - 1) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
	endfunction

	// ------------------------------------------------------------------
	// Directed steps. Frame of full-scale pixels and the shrink below the
	// live column have results that follow by hand; the mixed frame is
	// predicted.
	// ------------------------------------------------------------------
	dir_step_t directed_steps [26] = '{
		// line_length: bit 12 is not part of the register, so this is 5
		'{STEP_CFG, REG_LINE_LENGTH, 16'h1005, 1'b0, '0},
		// frame_rows below range saturates to 3
		'{STEP_CFG, REG_FRAME_ROWS,  16'h0000, 1'b0, '0},
		// first three pixels of row 0 at width 5
		'{STEP_PIX, 1'b1, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		// width below range -> 3; column count 3 is now past the last column
		'{STEP_CFG, REG_LINE_LENGTH, 16'h0001, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		// row sums clamp to 32767 -> 10922; three of them -> 10922
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b1, '{16'sd10922, 1'b1, 1'b1}},
		'{STEP_CFG, REG_FRAME_ROWS,  16'h0004, 1'b0, '0},
		// next frame with no frame_start: counts wrapped on their own
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h7fff, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h8000, 1'b0, '0},   // even row order
		'{STEP_PIX, 1'b0, 16'h5555, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'haaaa, 1'b0, '0},
		'{STEP_PIX, 1'b0, 16'h0000, 1'b0, '0}    // odd row order, frame end
	};

	// ------------------------------------------------------------------
	// Pixel side
	// ------------------------------------------------------------------

	// Offer one pixel request, wait for it to be taken, record what it yields.
	task automatic offer_pixel(input pix_t px, input logic fs,
			input logic use_typed, input blur_rec_t typed);
		logic      fs_eff;
		logic      produced;
		blur_rec_t rec;
		fs_eff        = fs | restart_frame;
		restart_frame = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel       <= px;
		pix_ch.frame_start <= fs_eff;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		blur_predict(px, fs_eff, produced, rec);
		if (use_typed)
			blur_expect.push_back(typed);
		else if (produced)
			blur_expect.push_back(rec);
	endtask

	// Quiet the input and let every outstanding result and any pixel still
	// in the line-memory pass finish before touching the registers.
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (blur_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		int old_len;
		old_len   = line_len();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_LINE_LENGTH)
			len_reg = val[11:0];
		else
			rows_reg = val;
		// a wider line would read line-sum entries never written this frame,
		// so the next request restarts the frame
		if (line_len() > old_len)
			restart_frame = 1'b1;
		@(posedge clk);
	endtask

	task automatic set_stage(input int stage);
		case (stage)
			0: begin
				send_idle_pct = 17;
				recv_idle_pct = 81;
			end
			1: begin
				send_idle_pct = 81;
				recv_idle_pct = 17;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready, long hold on request, in-order check
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		blur_rec_t got;
		blur_rec_t want;
		if (arst_n && blur_ch.valid && blur_ch.ready) begin
			got = '{blur_ch.blurred, blur_ch.row_end, blur_ch.frame_end};
			if (blur_expect.size() == 0) begin
				$error("result with none expected: blurred %0d row_end %0b frame_end %0b",
					got.blurred, got.row_end, got.frame_end);
				fail_count++;
			end else begin
				want = blur_expect.pop_front();
				if (got.blurred !== want.blurred) begin
					$error("blurred: expected %0d, got %0d", want.blurred, got.blurred);
					fail_count++;
				end
				if (got.row_end !== want.row_end) begin
					$error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
					fail_count++;
				end
				if (got.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
					fail_count++;
				end
			end
		end
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			blur_ch.ready <= 1'b0;
		end else begin
			blur_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		pix_t        px;
		logic        fs;
		int          n_pixels;
		bit          full_frame;
		bit          wr_len;
		bit          wr_rows;
		logic [12:0] len_val;
		logic [12:0] rows_val;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_LINE_LENGTH;
		cfg_data           = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel       = '0;
		pix_ch.frame_start = 1'b0;
		blur_ch.ready      = 1'b0;

		// predictor reset state
		foreach (line_sums[i, j])
			line_sums[i][j] = '0;
		recent_px     = '{'0, '0};
		next_col      = 0;
		next_row      = 0;
		len_reg       = LINE_LENGTH_RST;
		rows_reg      = FRAME_ROWS_RST;
		fail_count    = 0;
		restart_frame = 1'b0;
		hold_request  = 1'b0;
		hold_left     = 0;
		set_stage(0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_CFG) begin
				settle();
				write_reg(directed_steps[i].flag, directed_steps[i].data[12:0]);
			end else begin
				offer_pixel(directed_steps[i].data, directed_steps[i].flag,
					directed_steps[i].checked, directed_steps[i].result);
			end
		end

		// random phases: registers change only between phases, while idle
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_stage(p * 3 / NUM_PHASES);
			settle();
			n_pixels   = PHASE_PIXELS;
			full_frame = 1'b0;
			wr_len     = 1'b1;
			wr_rows    = 1'b1;
			case (p)
				0: begin   // smallest legal frame
					len_val  = 13'd3;
					rows_val = 13'd3;
				end
				4: begin   // widest line (4095 saturates), start of a fresh frame
					len_val    = 13'h0fff;
					rows_val   = 13'd3;
					full_frame = 1'b1;
				end
				9: begin   // tallest frame (8191 saturates), narrowest line
					len_val    = 13'd2;
					rows_val   = 13'h1fff;
					full_frame = 1'b1;
				end
				10: begin  // exact maxima, partial first row; next phase may shrink under it
					len_val  = 13'(MAX_LINE);
					rows_val = 13'(MAX_ROWS);
				end
				default: begin
					wr_len  = ($urandom_range(9) < 7);
					wr_rows = ($urandom_range(9) < 7);
					case ($urandom_range(9))
						0:       len_val = 13'($urandom_range(2));
						1:       len_val = 13'($urandom_range(64, 13));
						2:       len_val = {1'b1, 12'($urandom_range(10, 3))};
						default: len_val = 13'($urandom_range(12, 3));
					endcase
					case ($urandom_range(9))
						0:       rows_val = 13'($urandom_range(2));
						1:       rows_val = 13'($urandom_range(8191, MAX_ROWS + 1));
						default: rows_val = 13'($urandom_range(9, 3));
					endcase
				end
			endcase
			if (wr_len)
				write_reg(REG_LINE_LENGTH, len_val);
			if (wr_rows)
				write_reg(REG_FRAME_ROWS, rows_val);

			// output side blocks for a long stretch while requests keep coming
			if (p == 5 || p == 12)
				hold_request = 1'b1;

			for (int k = 0; k < n_pixels; k++) begin
				if (full_frame)
					fs = (k == 0);
				else
					fs = (k == 0 && $urandom_range(1) == 1) || ($urandom_range(99) < 2);
				case ($urandom_range(7))
					0:       px = 16'sh7fff;
					1:       px = 16'sh8000;
					2:       px = pix_t'($urandom_range(64)) - 16'sd32;
					default: px = pix_t'($urandom);
				endcase
				offer_pixel(px, fs, 1'b0, '0);
			end
		end

		settle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
